// File: rtl/utf8_codepoint_decoder_defines.svh
// Assertion macros for the UTF-8 codepoint decoder.
// Included by the modules that check their own logic; no other dependencies.
`ifndef UTF8_CODEPOINT_DECODER_DEFINES_SVH
`define UTF8_CODEPOINT_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define U8D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define U8D_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define U8D_ASSERT(lbl, prop, msg)
`define U8D_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/utf8d_pkg.sv
// Shared types, codes and tables of the UTF-8 codepoint decoder.
// No dependencies; imported by utf8d_core, utf8_codepoint_decoder, utf8_decode_checker and the testbench.
package utf8d_pkg;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_BAD_TRAIL = 3'd2,
		ERR_ILLEGAL   = 3'd3,
		ERR_TOO_HIGH  = 3'd4,
		ERR_SURROGATE = 3'd5,
		ERR_ZERO      = 3'd6
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [20:0] codepoint;
		logic [2:0]  byte_count;
		err_t        error_code;
	} out_item_t;

	// open sequence; the accumulator keeps only the bits the codepoint can use
	typedef struct packed {
		logic [7:0]  lead_value;
		logic [7:0]  second_value;
		logic [20:0] accumulator;
		logic [2:0]  trail_expected;
		logic [2:0]  trail_seen;
		logic        low_trail_flag;
		logic        range_bad_flag;
	} seq_state_t;

	localparam logic [7:0]  TRAIL_LO   = 8'h80;
	localparam logic [7:0]  TRAIL_HI   = 8'hBF;
	localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;

	function automatic logic [2:0] trail_count(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd5;
		if (b < 8'hC0)      n = 3'd0;
		else if (b < 8'hE0) n = 3'd1;
		else if (b < 8'hF0) n = 3'd2;
		else if (b < 8'hF8) n = 3'd3;
		else if (b < 8'hFC) n = 3'd4;
		return n;
	endfunction

	// lead and marker bits summed over the sequence, low 21 bits
	function automatic logic [20:0] trail_offset(input logic [2:0] n);
		logic [20:0] o;
		unique case (n)
			3'd0:    o = 21'h000000;
			3'd1:    o = 21'h003080;
			3'd2:    o = 21'h0E2080;
			3'd3:    o = 21'h082080;
			3'd4:    o = 21'h082080;
			3'd5:    o = 21'h082080;
			default: o = 21'h000000;
		endcase
		return o;
	endfunction

endpackage

// File: rtl/utf8d_core.sv
// Per-byte decode step: next sequence state and the result, if any.
// Purely combinational; depends on utf8d_pkg.
module utf8d_core
	import utf8d_pkg::*;
(
	input  seq_state_t st,
	input  in_item_t   item,
	input  logic       length_known,
	output seq_state_t st_next,
	output logic       res_valid,
	output out_item_t  res
);

	seq_state_t  w;
	logic        done;
	logic        short_end;
	logic [2:0]  n;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic        legal;
	logic [20:0] c;
	logic [7:0]  b;

	always_comb begin
		b = item.data_byte;
		w = st;
		if (st.trail_expected == 3'd0) begin
			w = '0;
			w.lead_value = b;
			w.accumulator = {13'd0, b};
			w.trail_expected = trail_count(b);
			done = (w.trail_expected == 3'd0);
		end else begin
			w.trail_seen = st.trail_seen + 3'd1;
			if (w.trail_seen == 3'd1)
				w.second_value = b;
			else if (b < TRAIL_LO || b > TRAIL_HI)
				w.range_bad_flag = 1'b1;
			if (b < TRAIL_LO)
				w.low_trail_flag = 1'b1;
			w.accumulator = {st.accumulator[14:0], 6'd0} + {13'd0, b};
			done = (w.trail_seen >= w.trail_expected);
		end
		short_end = !done && length_known && item.buffer_end;

		n = w.trail_expected;
		lo = TRAIL_LO;
		hi = TRAIL_HI;
		if (w.lead_value == 8'hE0)      lo = 8'hA0;
		else if (w.lead_value == 8'hED) hi = 8'h9F;
		else if (w.lead_value == 8'hF0) lo = 8'h90;
		else if (w.lead_value == 8'hF4) hi = 8'h8F;
		legal = (n <= 3'd3)
			&& !(w.lead_value >= 8'h80 && w.lead_value < 8'hC2)
			&& !(w.lead_value > 8'hF4)
			&& !w.range_bad_flag
			&& (n == 3'd0 || (w.second_value >= lo && w.second_value <= hi));
		c = w.accumulator - trail_offset(n);

		res = '0;
		res_valid = done || short_end;
		if (short_end) begin
			res.byte_count = w.trail_seen + 3'd1;
			res.error_code = ERR_SHORT;
		end else begin
			res.byte_count = n + 3'd1;
			if (!length_known && w.low_trail_flag) res.error_code = ERR_BAD_TRAIL;
			else if (!legal)                       res.error_code = ERR_ILLEGAL;
			else if (c > MAX_SCALAR)               res.error_code = ERR_TOO_HIGH;
			else if (c >= SURR_LO && c <= SURR_HI) res.error_code = ERR_SURROGATE;
			else if (c == 21'd0)                   res.error_code = ERR_ZERO;
			else begin
				res.error_code = ERR_OK;
				res.codepoint = c;
			end
		end

		st_next = res_valid ? seq_state_t'('0) : w;
	end

endmodule

// File: rtl/utf8_codepoint_decoder.sv
// Top level of the UTF-8 codepoint decoder: input register, sequence state,
// result register and configuration. Depends on utf8d_pkg, utf8d_core and
// utf8_codepoint_decoder_defines.svh.
//
// Takes one byte per cycle unless the result stalls and gives at most one
// result per byte (the byte enters the input register when it is accepted, its
// result enters the result register when that is not stalled); a byte that
// completes or breaks a sequence yields a codepoint or an error code, other
// bytes yield nothing. Sustained rate is one byte per clock, set by the single
// decode step between the input and result registers; a stalled result holds
// the input register and stalls the byte input. cfg_ready is always high;
// write length_known only while no bytes are in flight.
`include "utf8_codepoint_decoder_defines.svh"
module utf8_codepoint_decoder
	import utf8d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	logic       in_valid_s1;
	in_item_t   in_data_s1;
	seq_state_t seq_q;
	seq_state_t seq_next;
	logic       length_known_q;
	logic       res_valid;
	out_item_t  res;
	logic       advance;

	assign cfg_ready = 1'b1;
	assign advance = in_valid_s1 && (!out_valid || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	utf8d_core u_core (
		.st           (seq_q),
		.item         (in_data_s1),
		.length_known (length_known_q),
		.st_next      (seq_next),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid <= 1'b0;
			seq_q <= '0;
			length_known_q <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready)
				length_known_q <= cfg_data;
			if (in_valid && !in_stall)
				in_valid_s1 <= 1'b1;
			else if (advance)
				in_valid_s1 <= 1'b0;
			if (advance) begin
				seq_q <= seq_next;
				out_valid <= res_valid;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			in_data_s1 <= in_data;
		if (advance && res_valid)
			out_data <= res;
	end

	`U8D_ASSERT_IMPL(a_err_no_cp, out_valid && out_data.error_code != ERR_OK,
		out_data.codepoint == 21'd0, "codepoint set on an error result")
	`U8D_ASSERT_IMPL(a_ok_range, out_valid && out_data.error_code == ERR_OK,
		out_data.codepoint != 21'd0 && out_data.codepoint <= MAX_SCALAR,
		"decoded codepoint out of range")
	`U8D_ASSERT_IMPL(a_count_range, out_valid,
		out_data.byte_count >= 3'd1 && out_data.byte_count <= 3'd6,
		"byte count out of range")
	`U8D_ASSERT_IMPL(a_idle_clear, seq_q.trail_expected == 3'd0,
		seq_q.trail_seen == 3'd0, "trail bytes counted with no open sequence")
	`U8D_ASSERT_IMPL(a_open_seq, seq_q.trail_expected != 3'd0,
		seq_q.trail_seen < seq_q.trail_expected, "open sequence past its length")

endmodule

// File: tb/sv/utf8_decode_checker.sv
// Scoreboard for the UTF-8 codepoint decoder: watches the byte, result and
// configuration channels, predicts each result and compares the whole item.
// Depends on utf8d_pkg.
module utf8_decode_checker
	import utf8d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic      cfg_data,
	output int        pending,
	output int        errors
);

	logic        length_known;
	logic [7:0]  seq_lead;
	logic [7:0]  seq_second;
	logic [31:0] seq_acc;
	logic [2:0]  seq_trails;
	logic [2:0]  seq_seen;
	logic        seq_low_trail;
	logic        seq_range_bad;
	out_item_t   expected_results[$];
	out_item_t   want;

	function automatic logic [2:0] lead_trails(input logic [7:0] b);
		casez (b)
			8'b110?????: return 3'd1;
			8'b1110????: return 3'd2;
			8'b11110???: return 3'd3;
			8'b111110??: return 3'd4;
			8'b111111??: return 3'd5;
			default:     return 3'd0;
		endcase
	endfunction

	// marker bits of lead and trails summed with the shifts applied
	function automatic logic [31:0] lead_bias(input logic [2:0] n);
		case (n)
			3'd1:    return 32'h0000_3080;
			3'd2:    return 32'h000E_2080;
			3'd3:    return 32'h03C8_2080;
			3'd4:    return 32'hFA08_2080;
			3'd5:    return 32'h8208_2080;
			default: return 32'h0;
		endcase
	endfunction

	function automatic bit sequence_well_formed(input logic [2:0] n);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = TRAIL_LO;
		hi = TRAIL_HI;
		if (n > 3'd3) return 1'b0;
		if (seq_lead >= 8'h80 && seq_lead < 8'hC2) return 1'b0;
		if (seq_lead > 8'hF4) return 1'b0;
		if (seq_range_bad) return 1'b0;
		if (n >= 3'd1) begin
			case (seq_lead)
				8'hE0:   lo = 8'hA0;
				8'hED:   hi = 8'h9F;
				8'hF0:   lo = 8'h90;
				8'hF4:   hi = 8'h8F;
				default: ;
			endcase
			if (seq_second < lo || seq_second > hi) return 1'b0;
		end
		return 1'b1;
	endfunction

	task clear_sequence;
		seq_lead = '0;
		seq_second = '0;
		seq_acc = '0;
		seq_trails = '0;
		seq_seen = '0;
		seq_low_trail = 1'b0;
		seq_range_bad = 1'b0;
	endtask

	task record_result(input logic [20:0] cp, input logic [2:0] count, input err_t code);
		out_item_t r;
		r.codepoint = cp;
		r.byte_count = count;
		r.error_code = code;
		expected_results.push_back(r);
		clear_sequence();
	endtask

	task complete_sequence;
		logic [2:0]  n;
		logic [31:0] c;
		n = seq_trails;
		c = seq_acc - lead_bias(n);
		if (!length_known && seq_low_trail)
			record_result('0, n + 3'd1, ERR_BAD_TRAIL);
		else if (!sequence_well_formed(n))
			record_result('0, n + 3'd1, ERR_ILLEGAL);
		else if (c > MAX_SCALAR)
			record_result('0, n + 3'd1, ERR_TOO_HIGH);
		else if (c >= SURR_LO && c <= SURR_HI)
			record_result('0, n + 3'd1, ERR_SURROGATE);
		else if (c == 32'd0)
			record_result('0, n + 3'd1, ERR_ZERO);
		else
			record_result(c[20:0], n + 3'd1, ERR_OK);
	endtask

	task decode_byte(input in_item_t it);
		logic [7:0] b;
		b = it.data_byte;
		if (seq_trails == 3'd0) begin
			clear_sequence();
			seq_lead = b;
			seq_acc = {24'd0, b};
			seq_trails = lead_trails(b);
			if (seq_trails == 3'd0)
				complete_sequence();
			else if (length_known && it.buffer_end)
				record_result('0, 3'd1, ERR_SHORT);
		end else begin
			seq_seen = seq_seen + 3'd1;
			if (seq_seen == 3'd1)
				seq_second = b;
			else if (b < TRAIL_LO || b > TRAIL_HI)
				seq_range_bad = 1'b1;
			if (b < TRAIL_LO)
				seq_low_trail = 1'b1;
			seq_acc = (seq_acc << 6) + {24'd0, b};
			if (seq_seen >= seq_trails)
				complete_sequence();
			else if (length_known && it.buffer_end)
				record_result('0, seq_seen + 3'd1, ERR_SHORT);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_known = 1'b1;
			clear_sequence();
			expected_results.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				length_known = cfg_data;
			if (in_valid && !in_stall)
				decode_byte(in_data);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected item: expected none, got cp=%h count=%0d err=%0d",
						$time, out_data.codepoint, out_data.byte_count, out_data.error_code);
				end else begin
					want = expected_results.pop_front();
					if (out_data !== want) begin
						errors++;
						$display("%0t: expected cp=%h count=%0d err=%0d, got cp=%h count=%0d err=%0d",
							$time, want.codepoint, want.byte_count, want.error_code,
							out_data.codepoint, out_data.byte_count, out_data.error_code);
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: tb/sv/utf8_codepoint_decoder_tb.sv
// Top of the UTF-8 codepoint decoder testbench: clock, reset, byte stimulus,
// result stall, length_known writes, watchdog and verdict.
// Depends on utf8d_pkg, utf8_codepoint_decoder and utf8_decode_checker.
module utf8_codepoint_decoder_tb;
	import utf8d_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;
	int        pending;
	int        errors;
	int        send_idle = 0;
	int        recv_idle = 0;
	int        quiet_cycles = 0;
	int        bytes_sent = 0;
	logic [7:0] seq_bytes [0:5];

	utf8_codepoint_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	utf8_decode_checker decode_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= (recv_idle > 0) && ($urandom_range(0, 99) < recv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {b, last};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// drain, let the pipeline empty, then write the register
	task set_length_known(input logic v);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task send_random_sequence;
		int          kind;
		int          len;
		int          end_pos;
		int          i;
		logic [20:0] cp;
		logic [7:0]  lead;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: cp = 21'($urandom_range(0, 'h7F));
			1: cp = 21'($urandom_range('h80, 'h7FF));
			2: cp = ($urandom_range(0, 3) == 0) ? 21'($urandom_range('hD700, 'hE0FF))
				: 21'($urandom_range('h800, 'hFFFF));
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		if (cp < 21'h80) begin
			len = 1;
			seq_bytes[0] = {1'b0, cp[6:0]};
		end else if (cp < 21'h800) begin
			len = 2;
			seq_bytes[0] = {3'b110, cp[10:6]};
			seq_bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			len = 3;
			seq_bytes[0] = {4'b1110, cp[15:12]};
			seq_bytes[1] = {2'b10, cp[11:6]};
			seq_bytes[2] = {2'b10, cp[5:0]};
		end else begin
			len = 4;
			seq_bytes[0] = {5'b11110, cp[20:18]};
			seq_bytes[1] = {2'b10, cp[17:12]};
			seq_bytes[2] = {2'b10, cp[11:6]};
			seq_bytes[3] = {2'b10, cp[5:0]};
		end
		if (kind >= 55 && kind < 70) begin
			// boundary leads with in-range trails
			case ($urandom_range(0, 7))
				0: lead = 8'hC0;
				1: lead = 8'hC1;
				2: lead = 8'hE0;
				3: lead = 8'hED;
				4: lead = 8'hF0;
				5: lead = 8'hF4;
				default: lead = 8'($urandom_range('hC0, 'hFF));
			endcase
			len = (lead >= 8'hFC) ? 6 : (lead >= 8'hF8) ? 5 : (lead >= 8'hF0) ? 4
				: (lead >= 8'hE0) ? 3 : 2;
			seq_bytes[0] = lead;
			for (i = 1; i < len; i++)
				seq_bytes[i] = 8'($urandom_range('h80, 'hBF));
		end else if (kind >= 85) begin
			len = $urandom_range(1, 3);
			for (i = 0; i < len; i++)
				seq_bytes[i] = 8'($urandom_range(0, 255));
		end else if (kind >= 70 && len > 1) begin
			seq_bytes[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
		end
		end_pos = ($urandom_range(0, 99) < 12) ? $urandom_range(0, len - 1) : 6;
		for (i = 0; i < len; i++)
			send_byte(seq_bytes[i], i == end_pos);
	endtask

	initial begin
		int phase;
		int half;
		int target;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_length_known(1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hC2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF4, 1'b0);
		send_byte(8'h8F, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hE2, 1'b1);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFC, 1'b0);
		send_byte(8'h84, 1'b0);
		repeat (4) send_byte(8'h80, 1'b0);

		set_length_known(1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hE2, 1'b1);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 32;
					recv_idle = 49;
				end
				1: begin
					send_idle = 49;
					recv_idle = 32;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (half = 0; half < 2; half++) begin
				set_length_known(phase[0] ^ half[0]);
				target = bytes_sent + 250;
				while (bytes_sent < target) send_random_sequence();
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
